@@ sv/adam_parameter_update_top_assert.svh @@
// assertion macros for the adam parameter update block
// used by the top level only, no other dependencies
`ifndef ADAM_PARAMETER_UPDATE_TOP_ASSERT_SVH
`define ADAM_PARAMETER_UPDATE_TOP_ASSERT_SVH

// same-cycle implication under synchronous reset
`define APU_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication under synchronous reset
`define APU_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/apu_pkg.sv @@
// shared types and constants for the adam parameter update block
// no dependencies; used by the interfaces, the engine and the top level
package apu_pkg;

  localparam int MAX_PARAMS = 64;
  localparam int IDX_W      = $clog2(MAX_PARAMS);
  localparam int DATA_W     = 64;
  localparam int CFG_ADDR_W = 6;
  localparam int CNT_W      = 7;

  localparam logic [CNT_W-1:0] MUL_STEPS  = 7'd64;
  localparam logic [CNT_W-1:0] DIV_STEPS  = 7'd64;
  localparam logic [CNT_W-1:0] SQRT_STEPS = 7'd48;

  // item function codes
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_UPDATE = 1'b1;

  // register indexes on the configuration port
  localparam logic [2:0] REG_LEARNING_RATE  = 3'd0;
  localparam logic [2:0] REG_FIRST_DECAY    = 3'd1;
  localparam logic [2:0] REG_SECOND_DECAY   = 3'd2;
  localparam logic [2:0] REG_STABILITY_TERM = 3'd3;
  localparam logic [2:0] REG_CLAMP_VALUE    = 3'd4;

  localparam logic [31:0] LEARNING_RATE_RST  = 32'd4294967;
  localparam logic [31:0] FIRST_DECAY_RST    = 32'd4290672329;
  localparam logic [31:0] SECOND_DECAY_RST   = 32'd4290672329;
  localparam logic [31:0] STABILITY_TERM_RST = 32'd43;
  localparam logic [62:0] CLAMP_VALUE_RST    = 63'd429496730;

  localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

  typedef enum logic [1:0] {
    OP_MUL  = 2'd0,
    OP_DIV  = 2'd1,
    OP_SQRT = 2'd2
  } eng_op_t;

  // mul: opa*opb; div: {opa,opb}/opd; sqrt: floor(sqrt(opa*2^32))
  typedef struct packed {
    logic              start;
    eng_op_t           op;
    logic [DATA_W-1:0] opa;
    logic [DATA_W-1:0] opb;
    logic [DATA_W-1:0] opd;
  } eng_req_t;

  // mul: {hi,lo} product; div: lo quotient, ovf on overflow or zero divisor;
  // sqrt: hi root
  typedef struct packed {
    logic              busy;
    logic              done;
    logic              ovf;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] lo;
  } eng_rsp_t;

endpackage

@@ sv/apu_if.sv @@
// stream interfaces for the input and result channels
// depends on apu_pkg for field widths
interface apu_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic [apu_pkg::IDX_W-1:0]  index;
  logic [apu_pkg::DATA_W-1:0] value;
  logic                       end_of_step;

  modport source (output valid, func, index, value, end_of_step, input ready);
  modport sink   (input valid, func, index, value, end_of_step, output ready);
endinterface

interface apu_out_if;
  logic                       valid;
  logic                       ready;
  logic [apu_pkg::IDX_W-1:0]  out_index;
  logic [apu_pkg::DATA_W-1:0] param_value;

  modport source (output valid, out_index, param_value, input ready);
  modport sink   (input valid, out_index, param_value, output ready);
endinterface

@@ sv/adam_parameter_update_top.sv @@
// Adam update engine over a 64-entry parameter vector in Q32.32. A load beat
// passes through the load and output states, and the input is ready again
// once its result is registered. An update beat runs six multiplies,
// three divides and one square root, one after another, on a single shared
// unit that retires one bit per cycle; each multiply or divide holds the
// sequencer from issue through its bit steps to done, the root likewise
// through its digit steps, and a divide that overflows goes from issue
// straight to done. With end_of_step set, the two power updates add two more
// multiplies. The input is not ready while an item is in work; the result sits
// in an output register, and a result still waiting there holds the next item
// in its last state.
// Parameters and moments live in three 64x64 single-port memories.
// depends on apu_pkg, apu_if, apu_engine and the assertion macro header
`include "adam_parameter_update_top_assert.svh"

module adam_parameter_update_top (
  input  logic                           clk,
  input  logic                           rst_n,
  apu_in_if.sink                         in_ch,
  apu_out_if.source                      out_ch,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [apu_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [63:0]                    cfg_pwdata,
  output logic [63:0]                    cfg_prdata,
  output logic                           cfg_pready
);

  typedef enum logic [16:0] {
    ST_IDLE = 17'b0_0000_0000_0000_0001,
    ST_RD   = 17'b0_0000_0000_0000_0010,
    ST_LOAD = 17'b0_0000_0000_0000_0100,
    ST_MB   = 17'b0_0000_0000_0000_1000,
    ST_MG   = 17'b0_0000_0000_0001_0000,
    ST_GG   = 17'b0_0000_0000_0010_0000,
    ST_VB   = 17'b0_0000_0000_0100_0000,
    ST_VG   = 17'b0_0000_0000_1000_0000,
    ST_MH   = 17'b0_0000_0001_0000_0000,
    ST_VH   = 17'b0_0000_0010_0000_0000,
    ST_RT   = 17'b0_0000_0100_0000_0000,
    ST_AM   = 17'b0_0000_1000_0000_0000,
    ST_SD   = 17'b0_0001_0000_0000_0000,
    ST_PU   = 17'b0_0010_0000_0000_0000,
    ST_P1   = 17'b0_0100_0000_0000_0000,
    ST_P2   = 17'b0_1000_0000_0000_0000,
    ST_OUT  = 17'b1_0000_0000_0000_0000
  } state_t;

  localparam logic [63:0] ONES    = '1;
  localparam logic [63:0] POS_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] NEG_MIN = 64'h8000_0000_0000_0000;

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) return s[64] ? NEG_MIN : POS_MAX;
    return s[63:0];
  endfunction

  function automatic logic [63:0] sat_uadd(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? ONES : s[63:0];
  endfunction

  function automatic logic [63:0] mag(input logic [63:0] x);
    return x[63] ? 64'(-x) : x;
  endfunction

  // configuration
  logic [31:0] lr_r, b1_r, b2_r, eps_r;
  logic [62:0] clamp_r;
  logic        cfg_wr;

  // control and working registers
  state_t                    state_r, state_nxt;
  logic                      issued_r, issued_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [apu_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic [apu_pkg::IDX_W-1:0] out_idx_r, out_idx_nxt;
  logic [63:0]               out_val_r, out_val_nxt;
  logic                      func_r, func_nxt;
  logic                      eos_r, eos_nxt;
  logic [63:0]               g_r, g_nxt;
  logic [63:0]               m_r, m_nxt;
  logic [63:0]               v_r, v_nxt;
  logic [63:0]               s_r, s_nxt;
  logic [63:0]               mh_r, mh_nxt;
  logic [63:0]               den_r, den_nxt;
  logic [63:0]               res_r, res_nxt;
  logic [31:0]               pw1_r, pw1_nxt;
  logic [31:0]               pw2_r, pw2_nxt;

  // memories
  logic [63:0] param_mem [apu_pkg::MAX_PARAMS];
  logic [63:0] m_mem     [apu_pkg::MAX_PARAMS];
  logic [63:0] v_mem     [apu_pkg::MAX_PARAMS];
  logic [63:0] p_q, m_q, v_q;
  logic        we_p, we_mv;
  logic [63:0] wd_p, wd_m, wd_v;

  apu_pkg::eng_req_t eng_req;
  apu_pkg::eng_rsp_t eng_rsp;

  logic        arith;
  logic [63:0] scale, t_s, m_mag, step, newp;
  logic [32:0] omb1, omb2, omp1, omp2;

  apu_engine u_engine (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (eng_req),
    .rsp   (eng_rsp)
  );

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_paddr[5:3])
      apu_pkg::REG_LEARNING_RATE:  cfg_prdata = {32'd0, lr_r};
      apu_pkg::REG_FIRST_DECAY:    cfg_prdata = {32'd0, b1_r};
      apu_pkg::REG_SECOND_DECAY:   cfg_prdata = {32'd0, b2_r};
      apu_pkg::REG_STABILITY_TERM: cfg_prdata = {32'd0, eps_r};
      apu_pkg::REG_CLAMP_VALUE:    cfg_prdata = {1'b0, clamp_r};
      default:                     cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r    <= apu_pkg::LEARNING_RATE_RST;
      b1_r    <= apu_pkg::FIRST_DECAY_RST;
      b2_r    <= apu_pkg::SECOND_DECAY_RST;
      eps_r   <= apu_pkg::STABILITY_TERM_RST;
      clamp_r <= apu_pkg::CLAMP_VALUE_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[5:3])
        apu_pkg::REG_LEARNING_RATE:  lr_r    <= cfg_pwdata[31:0];
        apu_pkg::REG_FIRST_DECAY:    b1_r    <= cfg_pwdata[31:0];
        apu_pkg::REG_SECOND_DECAY:   b2_r    <= cfg_pwdata[31:0];
        apu_pkg::REG_STABILITY_TERM: eps_r   <= cfg_pwdata[31:0];
        apu_pkg::REG_CLAMP_VALUE:    clamp_r <= cfg_pwdata[62:0];
        default: begin
        end
      endcase
    end
  end

  assign in_ch.ready        = (state_r == ST_IDLE);
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_index   = out_idx_r;
  assign out_ch.param_value = out_val_r;

  assign omb1  = apu_pkg::ONE_Q32 - {1'b0, b1_r};
  assign omb2  = apu_pkg::ONE_Q32 - {1'b0, b2_r};
  assign omp1  = apu_pkg::ONE_Q32 - {1'b0, pw1_r};
  assign omp2  = apu_pkg::ONE_Q32 - {1'b0, pw2_r};
  assign scale = {eng_rsp.hi[31:0], eng_rsp.lo[63:32]};
  assign m_mag = mag(m_r);

  // operand selection for the shared unit
  always_comb begin
    eng_req.op  = apu_pkg::OP_MUL;
    eng_req.opa = '0;
    eng_req.opb = '0;
    eng_req.opd = '0;
    arith       = 1'b1;
    case (state_r)
      ST_MB: begin
        eng_req.opa = mag(m_q);
        eng_req.opb = {32'd0, b1_r};
      end
      ST_MG: begin
        eng_req.opa = mag(g_r);
        eng_req.opb = {31'd0, omb1};
      end
      ST_GG: begin
        eng_req.opa = mag(g_r);
        eng_req.opb = mag(g_r);
      end
      ST_VB: begin
        eng_req.opa = v_q;
        eng_req.opb = {32'd0, b2_r};
      end
      ST_VG: begin
        eng_req.opa = s_r;
        eng_req.opb = {31'd0, omb2};
      end
      ST_MH: begin
        eng_req.op  = apu_pkg::OP_DIV;
        eng_req.opa = {32'd0, m_mag[63:32]};
        eng_req.opb = {m_mag[31:0], 32'd0};
        eng_req.opd = {31'd0, omp1};
      end
      ST_VH: begin
        eng_req.op  = apu_pkg::OP_DIV;
        eng_req.opa = {32'd0, v_r[63:32]};
        eng_req.opb = {v_r[31:0], 32'd0};
        eng_req.opd = {31'd0, omp2};
      end
      ST_RT: begin
        eng_req.op  = apu_pkg::OP_SQRT;
        eng_req.opa = s_r;
      end
      ST_AM: begin
        eng_req.opa = {32'd0, lr_r};
        eng_req.opb = mh_r;
      end
      ST_SD: begin
        eng_req.op  = apu_pkg::OP_DIV;
        eng_req.opa = s_r;
        eng_req.opb = mh_r;
        eng_req.opd = den_r;
      end
      ST_P1: begin
        eng_req.opa = {32'd0, pw1_r};
        eng_req.opb = {32'd0, b1_r};
      end
      ST_P2: begin
        eng_req.opa = {32'd0, pw2_r};
        eng_req.opb = {32'd0, b2_r};
      end
      default: arith = 1'b0;
    endcase
    eng_req.start = arith & ~issued_r;
  end

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    issued_nxt    = issued_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    out_idx_nxt   = out_idx_r;
    out_val_nxt   = out_val_r;
    func_nxt      = func_r;
    eos_nxt       = eos_r;
    g_nxt         = g_r;
    m_nxt         = m_r;
    v_nxt         = v_r;
    s_nxt         = s_r;
    mh_nxt        = mh_r;
    den_nxt       = den_r;
    res_nxt       = res_r;
    pw1_nxt       = pw1_r;
    pw2_nxt       = pw2_r;
    we_p          = 1'b0;
    we_mv         = 1'b0;
    wd_p          = g_r;
    wd_m          = '0;
    wd_v          = '0;
    t_s           = '0;
    step          = '0;
    newp          = '0;

    if (out_valid_r && out_ch.ready) out_valid_nxt = 1'b0;
    if (eng_req.start) issued_nxt = 1'b1;
    if (eng_rsp.done) issued_nxt = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          idx_nxt   = in_ch.index;
          func_nxt  = in_ch.func;
          eos_nxt   = in_ch.end_of_step;
          g_nxt     = in_ch.value;
          state_nxt = (in_ch.func == apu_pkg::FUNC_UPDATE) ? ST_RD : ST_LOAD;
        end
      end
      ST_RD: state_nxt = ST_MB;
      ST_LOAD: begin
        we_p      = 1'b1;
        we_mv     = 1'b1;
        pw1_nxt   = b1_r;
        pw2_nxt   = b2_r;
        res_nxt   = g_r;
        state_nxt = ST_OUT;
      end
      ST_MB: if (eng_rsp.done) begin
        s_nxt     = m_q[63] ? 64'(-scale) : scale;
        state_nxt = ST_MG;
      end
      ST_MG: if (eng_rsp.done) begin
        t_s       = g_r[63] ? 64'(-scale) : scale;
        m_nxt     = sat_add(s_r, t_s);
        state_nxt = ST_GG;
      end
      ST_GG: if (eng_rsp.done) begin
        // g*g saturates once the integer part overflows
        s_nxt     = (eng_rsp.hi[63:32] != '0) ? ONES : scale;
        state_nxt = ST_VB;
      end
      ST_VB: if (eng_rsp.done) begin
        v_nxt     = scale;
        state_nxt = ST_VG;
      end
      ST_VG: if (eng_rsp.done) begin
        v_nxt     = sat_uadd(v_r, scale);
        state_nxt = ST_MH;
      end
      ST_MH: begin
        we_mv = 1'b1;
        wd_m  = m_r;
        wd_v  = v_r;
        if (eng_rsp.done) begin
          mh_nxt    = eng_rsp.ovf ? ONES : eng_rsp.lo;
          state_nxt = ST_VH;
        end
      end
      ST_VH: if (eng_rsp.done) begin
        s_nxt     = eng_rsp.ovf ? ONES : eng_rsp.lo;
        state_nxt = ST_RT;
      end
      ST_RT: if (eng_rsp.done) begin
        den_nxt   = eng_rsp.hi + {32'd0, eps_r};
        state_nxt = ST_AM;
      end
      ST_AM: if (eng_rsp.done) begin
        s_nxt     = eng_rsp.hi;
        mh_nxt    = eng_rsp.lo;
        state_nxt = ST_SD;
      end
      ST_SD: if (eng_rsp.done) begin
        // zero denominator with zero numerator gives no step
        if (eng_rsp.ovf)
          step = (den_r == '0 && s_r == '0 && mh_r == '0) ? '0 : ONES;
        else
          step = eng_rsp.lo;
        mh_nxt    = step[63] ? POS_MAX : step;
        state_nxt = ST_PU;
      end
      ST_PU: begin
        newp = m_r[63] ? sat_add(p_q, mh_r) : sat_add(p_q, 64'(-mh_r));
        if (newp[63]) newp = {1'b0, clamp_r};
        we_p      = 1'b1;
        wd_p      = newp;
        res_nxt   = newp;
        state_nxt = eos_r ? ST_P1 : ST_OUT;
      end
      ST_P1: if (eng_rsp.done) begin
        pw1_nxt   = scale[31:0];
        state_nxt = ST_P2;
      end
      ST_P2: if (eng_rsp.done) begin
        pw2_nxt   = scale[31:0];
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_idx_nxt   = idx_r;
          out_val_nxt   = res_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      issued_r    <= 1'b0;
      out_valid_r <= 1'b0;
      pw1_r       <= '0;
      pw2_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      issued_r    <= issued_nxt;
      out_valid_r <= out_valid_nxt;
      pw1_r       <= pw1_nxt;
      pw2_r       <= pw2_nxt;
    end
    idx_r     <= idx_nxt;
    out_idx_r <= out_idx_nxt;
    out_val_r <= out_val_nxt;
    func_r    <= func_nxt;
    eos_r     <= eos_nxt;
    g_r       <= g_nxt;
    m_r       <= m_nxt;
    v_r       <= v_nxt;
    s_r       <= s_nxt;
    mh_r      <= mh_nxt;
    den_r     <= den_nxt;
    res_r     <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (we_p) param_mem[idx_r] <= wd_p;
    if (we_mv) begin
      m_mem[idx_r] <= wd_m;
      v_mem[idx_r] <= wd_v;
    end
    p_q <= param_mem[idx_r];
    m_q <= m_mem[idx_r];
    v_q <= v_mem[idx_r];
  end

  `APU_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n,
    in_ch.valid && in_ch.ready && (func_nxt == apu_pkg::FUNC_LOAD),
    state_r == ST_LOAD, "load beat did not enter the load state")
  `APU_ASSERT_NEXT(a_result_held, clk, rst_n,
    state_r == ST_OUT && out_valid_r && !out_ch.ready,
    state_r == ST_OUT && out_valid_r, "pending result dropped or overwritten")
  `APU_ASSERT_IMPL(a_done_issued, clk, rst_n, eng_rsp.done, issued_r && arith,
    "shared unit finished without a request")

endmodule

@@ sv/apu_engine.sv @@
// shared iterative arithmetic unit: shift-add multiply, restoring divide,
// digit-by-digit square root, one bit (or root digit) per cycle; uses apu_pkg
module apu_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  apu_pkg::eng_req_t req,
  output apu_pkg::eng_rsp_t rsp
);

  apu_pkg::eng_op_t             op_r, op_nxt;
  logic                         busy_r, busy_nxt;
  logic                         done_r, done_nxt;
  logic                         ovf_r, ovf_nxt;
  logic [63:0]                  hi_r, hi_nxt;
  logic [63:0]                  lo_r, lo_nxt;
  logic [63:0]                  d_r, d_nxt;
  logic [51:0]                  rem_r, rem_nxt;
  logic [apu_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;

  logic [64:0] sum;
  logic [64:0] shv;
  logic        ge;
  logic [51:0] remsh;
  logic [51:0] trial;

  always_comb begin
    op_nxt   = op_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    ovf_nxt  = ovf_r;
    hi_nxt   = hi_r;
    lo_nxt   = lo_r;
    d_nxt    = d_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    sum      = '0;
    shv      = '0;
    ge       = 1'b0;
    remsh    = '0;
    trial    = '0;
    if (!busy_r) begin
      if (req.start) begin
        op_nxt  = req.op;
        ovf_nxt = 1'b0;
        case (req.op)
          apu_pkg::OP_MUL: begin
            hi_nxt   = '0;
            lo_nxt   = req.opb;
            d_nxt    = req.opa;
            cnt_nxt  = apu_pkg::MUL_STEPS;
            busy_nxt = 1'b1;
          end
          apu_pkg::OP_DIV: begin
            if (req.opd == '0 || req.opa >= req.opd) begin
              ovf_nxt  = 1'b1;
              done_nxt = 1'b1;
            end else begin
              hi_nxt   = req.opa;
              lo_nxt   = req.opb;
              d_nxt    = req.opd;
              cnt_nxt  = apu_pkg::DIV_STEPS;
              busy_nxt = 1'b1;
            end
          end
          apu_pkg::OP_SQRT: begin
            hi_nxt   = '0;
            lo_nxt   = req.opa;
            rem_nxt  = '0;
            cnt_nxt  = apu_pkg::SQRT_STEPS;
            busy_nxt = 1'b1;
          end
          default: begin
            ovf_nxt  = 1'b1;
            done_nxt = 1'b1;
          end
        endcase
      end
    end else begin
      case (op_r)
        apu_pkg::OP_MUL: begin
          sum    = {1'b0, hi_r} + (lo_r[0] ? {1'b0, d_r} : 65'd0);
          hi_nxt = sum[64:1];
          lo_nxt = {sum[0], lo_r[63:1]};
        end
        apu_pkg::OP_DIV: begin
          shv    = {hi_r, lo_r[63]};
          ge     = shv >= {1'b0, d_r};
          hi_nxt = ge ? 64'(shv - {1'b0, d_r}) : shv[63:0];
          lo_nxt = {lo_r[62:0], ge};
        end
        apu_pkg::OP_SQRT: begin
          remsh   = {rem_r[49:0], lo_r[63:62]};
          trial   = {2'b00, hi_r[47:0], 2'b01};
          ge      = remsh >= trial;
          rem_nxt = ge ? remsh - trial : remsh;
          hi_nxt  = {hi_r[62:0], ge};
          lo_nxt  = {lo_r[61:0], 2'b00};
        end
        default: begin
          hi_nxt = hi_r;
        end
      endcase
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      op_r   <= apu_pkg::OP_MUL;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      op_r   <= op_nxt;
      cnt_r  <= cnt_nxt;
    end
    ovf_r <= ovf_nxt;
    hi_r  <= hi_nxt;
    lo_r  <= lo_nxt;
    d_r   <= d_nxt;
    rem_r <= rem_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.ovf  = ovf_r;
  assign rsp.hi   = hi_r;
  assign rsp.lo   = lo_r;

endmodule

@@ dv/adam_parameter_update_top_tb.sv @@
// self-checking testbench for the adam parameter update block: drives load and
// gradient beats, rewrites the registers between phases and checks each result
// depends on apu_pkg, apu_if and adam_parameter_update_top
module adam_parameter_update_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] S64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

  typedef struct {
    logic [apu_pkg::IDX_W-1:0]  idx;
    logic [apu_pkg::DATA_W-1:0] val;
  } param_beat_t;

  class param_tracker;
    logic [31:0] alpha, beta1, beta2, eps;
    logic [62:0] clamp;
    logic [63:0] params [apu_pkg::MAX_PARAMS];
    logic [63:0] mom1 [apu_pkg::MAX_PARAMS];
    logic [63:0] mom2 [apu_pkg::MAX_PARAMS];
    logic [31:0] pow1, pow2;
    param_beat_t expected_params[$];
    int errors;

    function new();
      alpha = apu_pkg::LEARNING_RATE_RST;
      beta1 = apu_pkg::FIRST_DECAY_RST;
      beta2 = apu_pkg::SECOND_DECAY_RST;
      eps   = apu_pkg::STABILITY_TERM_RST;
      clamp = apu_pkg::CLAMP_VALUE_RST;
      pow1  = '0;
      pow2  = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [2:0] r, logic [63:0] d);
      case (r)
        apu_pkg::REG_LEARNING_RATE:  alpha = d[31:0];
        apu_pkg::REG_FIRST_DECAY:    beta1 = d[31:0];
        apu_pkg::REG_SECOND_DECAY:   beta2 = d[31:0];
        apu_pkg::REG_STABILITY_TERM: eps   = d[31:0];
        apu_pkg::REG_CLAMP_VALUE:    clamp = d[62:0];
        default: ;
      endcase
    endfunction

    function logic [63:0] scale_u(logic [63:0] x, logic [32:0] c);
      logic [127:0] p;
      p = {64'b0, x} * {95'b0, c};
      return p[95:32];
    endfunction

    function logic [63:0] scale_s(logic [63:0] x, logic [32:0] c);
      logic [63:0] r;
      r = scale_u(x[63] ? ~x + 64'd1 : x, c);
      return x[63] ? ~r + 64'd1 : r;
    endfunction

    function logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {a[63], a} + {b[63], b};
      if (s[64] != s[63]) return s[64] ? S64_MIN : S64_MAX;
      return s[63:0];
    endfunction

    function logic [63:0] sat_uadd(logic [63:0] a, logic [63:0] b);
      logic [64:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[64] ? '1 : s[63:0];
    endfunction

    // wide quotient, all ones when it does not fit or the divisor is zero
    function logic [63:0] div_sat(logic [127:0] n, logic [63:0] d);
      logic [127:0] q;
      if (d == 0 || n[127:64] >= d) return '1;
      q = n / {64'b0, d};
      return q[63:0];
    endfunction

    function logic [63:0] root_q32(logic [63:0] v);
      logic [127:0] tgt;
      logic [63:0] res, c;
      tgt = {32'b0, v, 32'b0};
      res = '0;
      for (int b = 47; b >= 0; b--) begin
        c = res | (64'd1 << b);
        if ({64'b0, c} * {64'b0, c} <= tgt) res = c;
      end
      return res;
    endfunction

    function logic [63:0] apply_gradient(int ix, logic [63:0] g);
      logic [63:0] gmag, g2, m, mmag, mh, vh, den, step, p;
      logic [127:0] sq, prod;
      gmag = g[63] ? ~g + 64'd1 : g;
      m = sat_add(scale_s(mom1[ix], {1'b0, beta1}),
                  scale_s(g, apu_pkg::ONE_Q32 - {1'b0, beta1}));
      mom1[ix] = m;
      sq = {64'b0, gmag} * {64'b0, gmag};
      g2 = (sq[127:96] != 0) ? '1 : sq[95:32];
      mom2[ix] = sat_uadd(scale_u(mom2[ix], {1'b0, beta2}),
                          scale_u(g2, apu_pkg::ONE_Q32 - {1'b0, beta2}));
      mmag = m[63] ? ~m + 64'd1 : m;
      // bias correction: divide by 1 - power
      mh = div_sat({32'b0, mmag, 32'b0}, {31'b0, apu_pkg::ONE_Q32} - {32'b0, pow1});
      vh = div_sat({32'b0, mom2[ix], 32'b0}, {31'b0, apu_pkg::ONE_Q32} - {32'b0, pow2});
      den = root_q32(vh) + {32'b0, eps};
      prod = {64'b0, 32'b0, alpha} * {64'b0, mh};
      if (den == 0) step = (prod != 0) ? '1 : '0;
      else step = div_sat(prod, den);
      if (step > S64_MAX) step = S64_MAX;
      p = params[ix];
      p = m[63] ? sat_add(p, step) : sat_add(p, ~step + 64'd1);
      if (p[63]) p = {1'b0, clamp};
      params[ix] = p;
      return p;
    endfunction

    function void note_item(logic func, logic [apu_pkg::IDX_W-1:0] idx, logic [63:0] val,
                            logic eos);
      param_beat_t e;
      logic [63:0] t;
      e.idx = idx;
      if (func == apu_pkg::FUNC_LOAD) begin
        params[idx] = val;
        mom1[idx] = '0;
        mom2[idx] = '0;
        e.val = val;
        pow1 = beta1;
        pow2 = beta2;
      end else begin
        e.val = apply_gradient(idx, val);
        if (eos) begin
          t = scale_u({32'b0, pow1}, {1'b0, beta1});
          pow1 = t[31:0];
          t = scale_u({32'b0, pow2}, {1'b0, beta2});
          pow2 = t[31:0];
        end
      end
      expected_params.push_back(e);
    endfunction

    function void check_result(logic [apu_pkg::IDX_W-1:0] idx, logic [63:0] val);
      param_beat_t e;
      if (expected_params.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result beat: index %0d value %h", idx, val);
        return;
      end
      e = expected_params.pop_front();
      if (e.idx !== idx || e.val !== val) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: index exp %0d got %0d, param exp %h got %h",
                   e.idx, idx, e.val, val);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [apu_pkg::CFG_ADDR_W-1:0] cfg_paddr = '0;
  logic [63:0] cfg_pwdata = '0;
  logic [63:0] cfg_prdata;
  logic cfg_pready;

  apu_in_if  in_ch ();
  apu_out_if out_ch ();

  param_tracker tracker = new();
  bit sender_idle = 1'b0;
  bit sink_idle = 1'b0;
  int hold_cycles = 0;
  bit loaded [apu_pkg::MAX_PARAMS];
  int loaded_list[$];

  adam_parameter_update_top i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  always #10 clk = ~clk;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = apu_pkg::FUNC_LOAD;
    in_ch.index = '0;
    in_ch.value = '0;
    in_ch.end_of_step = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        tracker.note_item(in_ch.func, in_ch.index, in_ch.value, in_ch.end_of_step);
      if (out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.out_index, out_ch.param_value);
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready)
        tracker.set_reg(cfg_paddr[5:3], cfg_pwdata);
    end
  end

  // result side: long hold-off on request, else random stall bursts while sink_idle is set
  initial begin
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_ch.ready <= 1'b0;
      end else begin
        if (sink_idle && burst == 0 && $urandom_range(0, 9) == 0) burst = $urandom_range(1, 12);
        if (burst > 0) begin
          burst--;
          out_ch.ready <= 1'b0;
        end else begin
          out_ch.ready <= 1'b1;
        end
      end
    end
  end

  // called at a falling edge, returns at a falling edge after the beat is taken
  task automatic send_item(logic func, int idx, logic [63:0] val, logic eos);
    if (sender_idle && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= func;
    in_ch.index <= idx[apu_pkg::IDX_W-1:0];
    in_ch.value <= val;
    in_ch.end_of_step <= eos;
    if (func == apu_pkg::FUNC_LOAD && !loaded[idx]) begin
      loaded[idx] = 1'b1;
      loaded_list.push_back(idx);
    end
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] r, logic [63:0] d);
    in_ch.valid <= 1'b0;
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {r, 3'b000};
    cfg_pwdata <= d;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    @(negedge clk);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (tracker.expected_params.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [63:0] pick_reg_value(logic [63:0] dflt);
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      2: return {$urandom, $urandom};
      default: return dflt;
    endcase
  endfunction

  function automatic logic [63:0] pick_value();
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(0, 7))
      0: return S64_MAX;
      1: return S64_MIN;
      2: return '0;
      3, 4: return {$urandom, $urandom};
      5: return {{16{r[31]}}, r, 16'($urandom)};
      default: return {{32{r[31]}}, r};
    endcase
  endfunction

  initial begin
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    sender_idle = 1'b1;
    sink_idle = 1'b1;
    @(negedge clk);

    // reset settings: extremes of the fields, end_of_step on a load is ignored
    send_item(apu_pkg::FUNC_LOAD, 0, S64_MAX, 1'b0);
    send_item(apu_pkg::FUNC_LOAD, 63, S64_MIN, 1'b1);
    send_item(apu_pkg::FUNC_LOAD, 5, '0, 1'b1);
    send_item(apu_pkg::FUNC_LOAD, 1, 64'h1_0000_0000, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 0, S64_MAX, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 63, S64_MIN, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 5, '0, 1'b1);
    send_item(apu_pkg::FUNC_UPDATE, 1, 64'h1_0000_0000, 1'b1);
    send_item(apu_pkg::FUNC_UPDATE, 1, 64'hffff_ffff_0000_0000, 1'b1);
    send_item(apu_pkg::FUNC_UPDATE, 0, S64_MIN, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 5, 64'h0000_0000_8000_0000, 1'b1);
    drain();

    // zero betas and zero eps: a tiny gradient leaves a zero denominator
    write_reg(apu_pkg::REG_FIRST_DECAY, '0);
    write_reg(apu_pkg::REG_SECOND_DECAY, '0);
    write_reg(apu_pkg::REG_STABILITY_TERM, '0);
    write_reg(apu_pkg::REG_LEARNING_RATE, '1);
    write_reg(apu_pkg::REG_CLAMP_VALUE, '1);
    send_item(apu_pkg::FUNC_LOAD, 2, 64'd5, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 2, 64'd1, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 2, '0, 1'b1);
    send_item(apu_pkg::FUNC_LOAD, 3, 64'h0000_0001_0000_0000, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 3, 64'hffff_ffff_ffff_ffff, 1'b1);
    drain();

    write_reg(apu_pkg::REG_FIRST_DECAY, '1);
    write_reg(apu_pkg::REG_SECOND_DECAY, '1);
    write_reg(apu_pkg::REG_CLAMP_VALUE, '0);
    send_item(apu_pkg::FUNC_LOAD, 4, 64'h0000_0010_0000_0000, 1'b0);
    send_item(apu_pkg::FUNC_UPDATE, 4, 64'h0000_0003_0000_0000, 1'b1);
    send_item(apu_pkg::FUNC_UPDATE, 4, 64'h0000_0003_0000_0000, 1'b1);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(apu_pkg::REG_LEARNING_RATE,
                pick_reg_value({32'b0, apu_pkg::LEARNING_RATE_RST}));
      write_reg(apu_pkg::REG_FIRST_DECAY,
                pick_reg_value({32'b0, apu_pkg::FIRST_DECAY_RST}));
      write_reg(apu_pkg::REG_SECOND_DECAY,
                pick_reg_value({32'b0, apu_pkg::SECOND_DECAY_RST}));
      write_reg(apu_pkg::REG_STABILITY_TERM,
                pick_reg_value({32'b0, apu_pkg::STABILITY_TERM_RST}));
      write_reg(apu_pkg::REG_CLAMP_VALUE,
                pick_reg_value({1'b0, apu_pkg::CLAMP_VALUE_RST}));
      if (ph == 5) begin
        sender_idle = 1'b0;
        sink_idle = 1'b0;
      end
      // the sink stops for a while so the block backs up into the input
      if (ph == 1) hold_cycles = 3000;
      for (int n = 0; n < 200; n++) begin
        int idx;
        if ($urandom_range(0, 3) == 0 || loaded_list.size() == 0) begin
          send_item(apu_pkg::FUNC_LOAD, $urandom_range(0, apu_pkg::MAX_PARAMS - 1),
                    pick_value(), $urandom_range(0, 7) == 0);
        end else begin
          idx = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
          send_item(apu_pkg::FUNC_UPDATE, idx, pick_value(), $urandom_range(0, 7) == 0);
        end
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (tracker.errors == 0 && tracker.expected_params.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("simulation failed");
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+sv
sv/apu_pkg.sv
sv/apu_if.sv
sv/apu_engine.sv
sv/adam_parameter_update_top.sv
dv/adam_parameter_update_top_tb.sv
